/* rtl/eknn_pkg.sv */
// ----------------------------------------------------------------------------
// eknn_pkg: shared types and constants for the k-nearest-neighbor search
// Request codes, sequencer states, sorted-list command and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package eknn_pkg;

   // fixed field geometry of the request and response ports
   localparam int FIELD_DIMS = 10;
   localparam int FIELD_BITS = 4;
   localparam int DIST_W     = 12;
   localparam int TYPE_W     = 2;

   // neighbor list
   localparam int LIST_MAX = 64;
   localparam int K_W      = 6;
   localparam logic [K_W-1:0] NBR_RESET = 6'd24;

   // parameter defaults
   localparam int MAX_POINTS_DEF = 512;
   localparam int DIMS_DEF       = 10;
   localparam int COORD_BITS_DEF = 4;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_LOAD  = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_QUERY = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // operation on the sorted neighbor list
   typedef struct packed {
      logic clear;
      logic insert;
      logic shift;
   } sort_cmd_type;

endpackage

`default_nettype wire

/* rtl/eknn_ram.sv */
// ----------------------------------------------------------------------------
// eknn_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module eknn_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

/* rtl/eknn_dist.sv */
// ----------------------------------------------------------------------------
// eknn_dist: squared Euclidean distance unit
// Two stages: per-dimension squares, then the sum. One point per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module eknn_dist
   import eknn_pkg::*;
#(
   parameter int DIMS       = DIMS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int IDX_W      = 9
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire logic [DIMS*COORD_BITS-1:0] query,
   input  wire logic [DIMS*COORD_BITS-1:0] point,
   input  wire logic [IDX_W-1:0]           in_idx,
   output logic                            pend,
   output logic                            out_valid,
   output logic      [DIST_W-1:0]          out_dist,
   output logic      [IDX_W-1:0]           out_idx
);

   logic [COORD_BITS:0]     diff   [DIMS];
   logic [COORD_BITS:0]     neg    [DIMS];
   logic [COORD_BITS-1:0]   mag    [DIMS];
   logic [2*COORD_BITS-1:0] sq_in  [DIMS];
   logic [2*COORD_BITS-1:0] sq_ff  [DIMS];
   logic [DIST_W-1:0]       sum;
   logic                    va_ff;
   logic                    vb_ff;
   logic [IDX_W-1:0]        idx_a_ff;
   logic [IDX_W-1:0]        idx_b_ff;
   logic [DIST_W-1:0]       dist_ff;

   always_comb begin
      for (int d = 0; d < DIMS; d++) begin
         diff[d]  = {1'b0, query[d*COORD_BITS +: COORD_BITS]}
                  - {1'b0, point[d*COORD_BITS +: COORD_BITS]};
         neg[d]   = '0 - diff[d];
         mag[d]   = diff[d][COORD_BITS] ? neg[d][COORD_BITS-1:0]
                                        : diff[d][COORD_BITS-1:0];
         sq_in[d] = (2*COORD_BITS)'(mag[d]) * (2*COORD_BITS)'(mag[d]);
      end
   end

   always_comb begin
      sum = '0;
      for (int d = 0; d < DIMS; d++) begin
         sum = sum + DIST_W'(sq_ff[d]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int d = 0; d < DIMS; d++) begin
         sq_ff[d] <= sq_in[d];
      end
      idx_a_ff <= in_idx;
      dist_ff  <= sum;
      idx_b_ff <= idx_a_ff;
   end

   assign pend      = va_ff;
   assign out_valid = vb_ff;
   assign out_dist  = dist_ff;
   assign out_idx   = idx_b_ff;

endmodule

`default_nettype wire

/* rtl/eknn_sorter.sv */
// ----------------------------------------------------------------------------
// eknn_sorter: sorted list of nearest distinct distances
// Row of cells, ascending by distance; insert drops duplicates, shift pops
// the head, clear empties the list.
// ----------------------------------------------------------------------------
`default_nettype none

module eknn_sorter
   import eknn_pkg::*;
#(
   parameter int IDX_W = 9
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sort_cmd_type      cmd,
   input  wire logic [DIST_W-1:0] cand_dist,
   input  wire logic [IDX_W-1:0]  cand_idx,
   output logic                   head_valid,
   output logic      [DIST_W-1:0] head_dist,
   output logic      [IDX_W-1:0]  head_idx
);

   logic [LIST_MAX-1:0] valid_ff;
   logic [LIST_MAX-1:0] valid_in;
   logic [DIST_W-1:0]   dist_ff [LIST_MAX];
   logic [DIST_W-1:0]   dist_in [LIST_MAX];
   logic [IDX_W-1:0]    idx_ff  [LIST_MAX];
   logic [IDX_W-1:0]    idx_in  [LIST_MAX];
   logic [LIST_MAX-1:0] lt;
   logic [LIST_MAX-1:0] eq;
   logic                dup;

   // empty cells count as infinitely far
   always_comb begin
      for (int j = 0; j < LIST_MAX; j++) begin
         lt[j] = !valid_ff[j] || (cand_dist < dist_ff[j]);
         eq[j] = valid_ff[j] && (cand_dist == dist_ff[j]);
      end
      dup = |eq;
   end

   always_comb begin
      for (int j = 0; j < LIST_MAX; j++) begin
         valid_in[j] = valid_ff[j];
         dist_in[j]  = dist_ff[j];
         idx_in[j]   = idx_ff[j];
         if (cmd.clear) begin
            valid_in[j] = 1'b0;
         end else if (cmd.shift) begin
            if (j == LIST_MAX-1) begin
               valid_in[j] = 1'b0;
            end else begin
               valid_in[j] = valid_ff[j+1];
               dist_in[j]  = dist_ff[j+1];
               idx_in[j]   = idx_ff[j+1];
            end
         end else if (cmd.insert && !dup) begin
            if (j > 0 && lt[(j > 0) ? j-1 : 0]) begin
               valid_in[j] = valid_ff[(j > 0) ? j-1 : 0];
               dist_in[j]  = dist_ff[(j > 0) ? j-1 : 0];
               idx_in[j]   = idx_ff[(j > 0) ? j-1 : 0];
            end else if (lt[j]) begin
               valid_in[j] = 1'b1;
               dist_in[j]  = cand_dist;
               idx_in[j]   = cand_idx;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < LIST_MAX; j++) begin
         dist_ff[j] <= dist_in[j];
         idx_ff[j]  <= idx_in[j];
      end
   end

   assign head_valid = valid_ff[0];
   assign head_dist  = dist_ff[0];
   assign head_idx   = idx_ff[0];

endmodule

`default_nettype wire

/* rtl/euclidean_k_nearest_neighbors.sv */
// ----------------------------------------------------------------------------
// euclidean_k_nearest_neighbors: brute-force k-NN search, squared distance
// Point store, scanning sequencer, distance unit and sorted neighbor list.
// ----------------------------------------------------------------------------
// A load request appends its point to the store (dropped when the store is
// full), a clear request empties it; neither returns anything.
// A query request scans every stored point once in load order through one
// distance unit, one point per cycle, and keeps the nearest distinct squared
// distances in a sorted list (first-loaded point wins a tie). It then emits
// num_neighbors+1 responses, nearest first, one per cycle on rsp_valid, with
// zero padding when too few distinct distances exist; rsp_last marks the
// final one. The receiver cannot stall: every response shows for exactly one
// cycle. While a query runs busy stays high: the scan reads the store once
// per point, the distance pipeline then drains, and the list is popped once
// per response during the emission.
// num_neighbors is sampled when a query is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module euclidean_k_nearest_neighbors
   import eknn_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int DIMS       = DIMS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [TYPE_W-1:0]     req_type,
   input  wire logic [FIELD_BITS-1:0] req_coord_0,
   input  wire logic [FIELD_BITS-1:0] req_coord_1,
   input  wire logic [FIELD_BITS-1:0] req_coord_2,
   input  wire logic [FIELD_BITS-1:0] req_coord_3,
   input  wire logic [FIELD_BITS-1:0] req_coord_4,
   input  wire logic [FIELD_BITS-1:0] req_coord_5,
   input  wire logic [FIELD_BITS-1:0] req_coord_6,
   input  wire logic [FIELD_BITS-1:0] req_coord_7,
   input  wire logic [FIELD_BITS-1:0] req_coord_8,
   input  wire logic [FIELD_BITS-1:0] req_coord_9,
   // response channel
   output logic                       rsp_valid,
   output logic      [FIELD_BITS-1:0] rsp_nb_0,
   output logic      [FIELD_BITS-1:0] rsp_nb_1,
   output logic      [FIELD_BITS-1:0] rsp_nb_2,
   output logic      [FIELD_BITS-1:0] rsp_nb_3,
   output logic      [FIELD_BITS-1:0] rsp_nb_4,
   output logic      [FIELD_BITS-1:0] rsp_nb_5,
   output logic      [FIELD_BITS-1:0] rsp_nb_6,
   output logic      [FIELD_BITS-1:0] rsp_nb_7,
   output logic      [FIELD_BITS-1:0] rsp_nb_8,
   output logic      [FIELD_BITS-1:0] rsp_nb_9,
   output logic      [DIST_W-1:0]     rsp_sq_distance,
   output logic                       rsp_last,
   // num_neighbors register write
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [K_W-1:0]        csr_data
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int PT_W  = DIMS * COORD_BITS;

   // sequencer
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;   // stored points
   logic [CNT_W-1:0] addr_ff, addr_in;     // scan pointer
   logic [K_W-1:0]   out_cnt_ff, out_cnt_in;
   logic [K_W-1:0]   k_last_ff;            // index of the final response
   logic [K_W-1:0]   nbr_ff;
   logic             query_load;
   logic             emit_step;
   sort_cmd_type     sort_cmd;

   // store
   logic             ram_we;
   logic             ram_re;
   logic [IDX_W-1:0] ram_raddr;
   logic [PT_W-1:0]  ram_rdata;
   logic [PT_W-1:0]  qin;
   logic [PT_W-1:0]  query_ff;

   // read stage of the scan
   logic             s1_valid_ff, s1_valid_in;
   logic [IDX_W-1:0] s1_idx_ff;

   // distance unit output
   logic              dist_pend;
   logic              dist_valid;
   logic [DIST_W-1:0] dist_val;
   logic [IDX_W-1:0]  dist_idx;

   // list head
   logic              head_valid;
   logic [DIST_W-1:0] head_dist;
   logic [IDX_W-1:0]  head_idx;

   // response stage
   logic              em_valid_ff;
   logic              em_real_ff;
   logic [DIST_W-1:0] em_dist_ff;
   logic              em_last_ff;

   logic [FIELD_BITS-1:0] coord_in [FIELD_DIMS];
   logic [FIELD_BITS-1:0] nb_out   [FIELD_DIMS];

   assign coord_in[0] = req_coord_0;
   assign coord_in[1] = req_coord_1;
   assign coord_in[2] = req_coord_2;
   assign coord_in[3] = req_coord_3;
   assign coord_in[4] = req_coord_4;
   assign coord_in[5] = req_coord_5;
   assign coord_in[6] = req_coord_6;
   assign coord_in[7] = req_coord_7;
   assign coord_in[8] = req_coord_8;
   assign coord_in[9] = req_coord_9;

   // keep only the used dimensions and coordinate bits
   for (genvar d = 0; d < DIMS; d++) begin : g_qin
      assign qin[d*COORD_BITS +: COORD_BITS] = coord_in[d][COORD_BITS-1:0];
   end

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         addr_ff     <= '0;
         out_cnt_ff  <= '0;
         nbr_ff      <= NBR_RESET;
         s1_valid_ff <= 1'b0;
         em_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         addr_ff     <= addr_in;
         out_cnt_ff  <= out_cnt_in;
         s1_valid_ff <= s1_valid_in;
         em_valid_ff <= emit_step;
         if (csr_valid && csr_ready) begin
            nbr_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (query_load) begin
         query_ff  <= qin;
         k_last_ff <= nbr_ff;
      end
      s1_idx_ff  <= addr_ff[IDX_W-1:0];
      em_real_ff <= head_valid;
      em_dist_ff <= head_dist;
      em_last_ff <= (out_cnt_ff == k_last_ff);
   end

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      addr_in         = addr_ff;
      out_cnt_in      = out_cnt_ff;
      ram_we          = 1'b0;
      ram_re          = 1'b0;
      ram_raddr       = addr_ff[IDX_W-1:0];
      s1_valid_in     = 1'b0;
      query_load      = 1'b0;
      emit_step       = 1'b0;
      sort_cmd        = '0;
      sort_cmd.insert = dist_valid;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_type)
                  REQ_LOAD: begin
                     // a full store ignores the load
                     if (count_ff < CNT_W'(MAX_POINTS)) begin
                        ram_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  REQ_QUERY: begin
                     query_load     = 1'b1;
                     sort_cmd.clear = 1'b1;
                     addr_in        = '0;
                     state_in       = ST_SCAN;
                  end
                  REQ_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (addr_ff < count_ff) begin
               ram_re      = 1'b1;
               s1_valid_in = 1'b1;
               addr_in     = addr_ff + 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // wait for the last candidate to land in the list
            if (!s1_valid_ff && !dist_pend && !dist_valid) begin
               out_cnt_in = '0;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // pop the head; its point comes out of the store on the next cycle
            emit_step      = 1'b1;
            sort_cmd.shift = 1'b1;
            ram_re         = head_valid;
            ram_raddr      = head_idx;
            out_cnt_in     = out_cnt_ff + 1'b1;
            if (out_cnt_ff == k_last_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // datapath
   // ---------------------------------------------------------------------
   eknn_ram #(
      .WIDTH (PT_W),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[IDX_W-1:0]),
      .wdata (qin),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   eknn_dist #(
      .DIMS       (DIMS),
      .COORD_BITS (COORD_BITS),
      .IDX_W      (IDX_W)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .query     (query_ff),
      .point     (ram_rdata),
      .in_idx    (s1_idx_ff),
      .pend      (dist_pend),
      .out_valid (dist_valid),
      .out_dist  (dist_val),
      .out_idx   (dist_idx)
   );

   eknn_sorter #(
      .IDX_W (IDX_W)
   ) u_sorter (
      .clock      (clock),
      .reset      (reset),
      .cmd        (sort_cmd),
      .cand_dist  (dist_val),
      .cand_idx   (dist_idx),
      .head_valid (head_valid),
      .head_dist  (head_dist),
      .head_idx   (head_idx)
   );

   // ---------------------------------------------------------------------
   // response: padding entries read as all zero
   // ---------------------------------------------------------------------
   for (genvar d = 0; d < FIELD_DIMS; d++) begin : g_nb
      if (d < DIMS) begin : g_used
         assign nb_out[d] = em_real_ff
                          ? FIELD_BITS'(ram_rdata[d*COORD_BITS +: COORD_BITS])
                          : '0;
      end else begin : g_unused
         assign nb_out[d] = '0;
      end
   end

   assign rsp_valid       = em_valid_ff;
   assign rsp_last        = em_valid_ff && em_last_ff;
   assign rsp_sq_distance = em_real_ff ? em_dist_ff : '0;
   assign rsp_nb_0        = nb_out[0];
   assign rsp_nb_1        = nb_out[1];
   assign rsp_nb_2        = nb_out[2];
   assign rsp_nb_3        = nb_out[3];
   assign rsp_nb_4        = nb_out[4];
   assign rsp_nb_5        = nb_out[5];
   assign rsp_nb_6        = nb_out[6];
   assign rsp_nb_7        = nb_out[7];
   assign rsp_nb_8        = nb_out[8];
   assign rsp_nb_9        = nb_out[9];

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond store depth");

   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_IDLE))
      else $error("store written during a query");

   a_no_insert_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_EMIT) |-> !dist_valid)
      else $error("distance candidate outside the scan");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_last |=> !rsp_valid)
      else $error("response after the final one");

   a_emit_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_EMIT))
      else $error("response without a list pop");

endmodule

`default_nettype wire
